/* design/rcf_pkg.sv */
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and constants for the rectangle/circle fill engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

  // default sizes, handed to the top level parameters
  localparam int MaxWidthDef  = 128;
  localparam int MaxHeightDef = 128;
  localparam int PixelBitsDef = 32;

  // fixed field widths
  localparam int CmdW   = 2;
  localparam int PosW   = 7;
  localparam int CoordW = 8;
  localparam int SqW    = 2 * CoordW;
  localparam int ColorW = 32;
  localparam int CntW   = 15;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 1;

  // command queue between front and back
  localparam int QDepth = 2;

  // reset values of the size registers
  localparam logic [CfgW-1:0] FrameWidthRst  = 8'd128;
  localparam logic [CfgW-1:0] FrameHeightRst = 8'd128;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  // command codes
  localparam logic [CmdW-1:0] CmdFillRect = 2'd0;
  localparam logic [CmdW-1:0] CmdFillCirc = 2'd1;
  localparam logic [CmdW-1:0] CmdReadPix  = 2'd2;

  typedef enum logic [1:0] {
    KIND_RECT = 2'd0,
    KIND_CIRC = 2'd1,
    KIND_READ = 2'd2,
    KIND_NOP  = 2'd3
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_READ,
    BK_RDWAIT,
    BK_DONE
  } back_state_e;

  // classified command: inclusive scan box plus what the scan needs
  typedef struct packed {
    cmd_kind_e          kind;
    logic               empty;
    logic [CoordW-1:0]  x0;
    logic [CoordW-1:0]  x1;
    logic [CoordW-1:0]  y0;
    logic [CoordW-1:0]  y1;
    logic [PosW-1:0]    cx;
    logic [PosW-1:0]    cy;
    logic [SqW-1:0]     r2;
    logic [CoordW-1:0]  stride;
    logic [ColorW-1:0]  color;
  } desc_t;

endpackage

`default_nettype wire

/* design/rect_circle_fill_engine_core.sv */
// ----------------------------------------------------------------------------
// rect_circle_fill_engine_core
// Rectangle/circle fill engine over an on-chip frame store, with pixel read.
//
//   port group      direction  handshake
//   command         in         start_i / busy_o, word taken when start_i & !busy_o
//   result          out        done_o strobe, one cycle, no back-pressure
//   size registers  in         cfg_we_i write, index cfg_idx_i, data cfg_wdata_i
//
// Fills scan one pixel per cycle and write those inside the shape; in the back
// end a fill passes dequeue, box scan, pipe drain and result, a read passes
// dequeue, read, read wait and result, and an empty box only dequeue and result.
// The scan rate is set by the single frame store write port. After reset all
// MAX_WIDTH*MAX_HEIGHT pixels (16384 by default) are cleared one pixel a cycle,
// with busy_o high; size writes are taken meanwhile. A two-deep command queue
// lets new words in during a scan; busy_o rises when it is full or while clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_circle_fill_engine_core #(
  parameter int MAX_WIDTH  = rcf_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = rcf_pkg::MaxHeightDef,
  parameter int PIXEL_BITS = rcf_pkg::PixelBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [rcf_pkg::CmdW-1:0]    command_i,
  input  wire logic [rcf_pkg::PosW-1:0]    x_a_i,
  input  wire logic [rcf_pkg::PosW-1:0]    y_a_i,
  input  wire logic [rcf_pkg::CoordW-1:0]  x_b_i,
  input  wire logic [rcf_pkg::CoordW-1:0]  y_b_i,
  input  wire logic [rcf_pkg::CoordW-1:0]  radius_i,
  input  wire logic [rcf_pkg::ColorW-1:0]  color_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [rcf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rcf_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                             done_o,
  output logic [rcf_pkg::ColorW-1:0]       read_color_o,
  output logic [rcf_pkg::CntW-1:0]         pixels_written_o
);
  import rcf_pkg::*;

  desc_t push_desc, pop_desc;
  logic  push, pop, q_full, q_empty, clearing;

  rcf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .command_i   (command_i),
    .x_a_i       (x_a_i),
    .y_a_i       (y_a_i),
    .x_b_i       (x_b_i),
    .y_b_i       (y_b_i),
    .radius_i    (radius_i),
    .color_i     (color_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .busy_o      (busy_o),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  rcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_desc),
    .pop_i   (pop),
    .data_o  (pop_desc),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rcf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_desc_i         (pop_desc),
    .q_pop_o          (pop),
    .clearing_o       (clearing),
    .done_o           (done_o),
    .read_color_o     (read_color_o),
    .pixels_written_o (pixels_written_o)
  );

endmodule

`default_nettype wire

/* design/rcf_front.sv */
// ----------------------------------------------------------------------------
// rcf_front
// Takes commands, holds the frame size registers and turns each command
// into a clamped, inclusive scan box for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_front #(
  parameter int MAX_WIDTH  = rcf_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = rcf_pkg::MaxHeightDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rcf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rcf_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        start_i,
  input  wire logic [rcf_pkg::CmdW-1:0]    command_i,
  input  wire logic [rcf_pkg::PosW-1:0]    x_a_i,
  input  wire logic [rcf_pkg::PosW-1:0]    y_a_i,
  input  wire logic [rcf_pkg::CoordW-1:0]  x_b_i,
  input  wire logic [rcf_pkg::CoordW-1:0]  y_b_i,
  input  wire logic [rcf_pkg::CoordW-1:0]  radius_i,
  input  wire logic [rcf_pkg::ColorW-1:0]  color_i,
  input  wire logic                        q_full_i,
  input  wire logic                        clearing_i,
  output logic                             busy_o,
  output logic                             push_o,
  output rcf_pkg::desc_t                   desc_o
);
  import rcf_pkg::*;

  localparam int WCap = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int HCap = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

  logic [CfgW-1:0] frame_width_q, frame_height_q;
  logic [CoordW-1:0] w_act, h_act, w_m1, h_m1;
  logic [CoordW-1:0] xa_e, ya_e;
  logic [CoordW-1:0] xb_c, yb_c;
  logic [CoordW-1:0] c_x0, c_y0, c_x1, c_y1;
  logic [CoordW:0]   c_xs, c_ys;
  logic              r_empty, c_empty, rd_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameWidth:  frame_width_q  <= cfg_wdata_i;
        RegFrameHeight: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = q_full_i || clearing_i;
  assign push_o = start_i && !busy_o;

  // size registers saturated to the supported range
  always_comb begin
    if (frame_width_q == '0)                w_act = 8'd1;
    else if (frame_width_q > CoordW'(WCap)) w_act = CoordW'(WCap);
    else                                    w_act = frame_width_q;
    if (frame_height_q == '0)                h_act = 8'd1;
    else if (frame_height_q > CoordW'(HCap)) h_act = CoordW'(HCap);
    else                                     h_act = frame_height_q;
  end

  assign w_m1 = w_act - 8'd1;
  assign h_m1 = h_act - 8'd1;
  assign xa_e = {1'b0, x_a_i};
  assign ya_e = {1'b0, y_a_i};

  // rectangle: half-open edges cut at the frame
  assign xb_c    = (x_b_i > w_act) ? w_act : x_b_i;
  assign yb_c    = (y_b_i > h_act) ? h_act : y_b_i;
  assign r_empty = (xa_e >= xb_c) || (ya_e >= yb_c);

  // circle: bounding box clamped at 0 and at size-1
  assign c_x0    = (xa_e > radius_i) ? xa_e - radius_i : '0;
  assign c_y0    = (ya_e > radius_i) ? ya_e - radius_i : '0;
  assign c_xs    = {1'b0, xa_e} + {1'b0, radius_i};
  assign c_ys    = {1'b0, ya_e} + {1'b0, radius_i};
  assign c_x1    = (c_xs > {1'b0, w_m1}) ? w_m1 : c_xs[CoordW-1:0];
  assign c_y1    = (c_ys > {1'b0, h_m1}) ? h_m1 : c_ys[CoordW-1:0];
  assign c_empty = (c_x0 > c_x1) || (c_y0 > c_y1);

  assign rd_empty = (xa_e >= w_act) || (ya_e >= h_act);

  always_comb begin
    desc_o        = '0;
    desc_o.kind   = KIND_NOP;
    desc_o.empty  = 1'b1;
    desc_o.cx     = x_a_i;
    desc_o.cy     = y_a_i;
    desc_o.r2     = radius_i * radius_i;
    desc_o.stride = w_act;
    desc_o.color  = color_i;
    case (command_i)
      CmdFillRect: begin
        desc_o.kind  = KIND_RECT;
        desc_o.empty = r_empty;
        desc_o.x0    = xa_e;
        desc_o.x1    = xb_c - 8'd1;
        desc_o.y0    = ya_e;
        desc_o.y1    = yb_c - 8'd1;
      end
      CmdFillCirc: begin
        desc_o.kind  = KIND_CIRC;
        desc_o.empty = c_empty;
        desc_o.x0    = c_x0;
        desc_o.x1    = c_x1;
        desc_o.y0    = c_y0;
        desc_o.y1    = c_y1;
      end
      CmdReadPix: begin
        desc_o.kind  = KIND_READ;
        desc_o.empty = rd_empty;
        desc_o.x0    = xa_e;
        desc_o.x1    = xa_e;
        desc_o.y0    = ya_e;
        desc_o.y1    = ya_e;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/rcf_queue.sv */
// ----------------------------------------------------------------------------
// rcf_queue
// Small command FIFO between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rcf_pkg::desc_t data_i,
  input  wire logic           pop_i,
  output rcf_pkg::desc_t      data_o,
  output logic                full_o,
  output logic                empty_o
);
  import rcf_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntQW = $clog2(QDepth + 1);

  desc_t             entry_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0]  count_q;

  assign full_o  = count_q == CntQW'(QDepth);
  assign empty_o = count_q == '0;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* design/rcf_back.sv */
// ----------------------------------------------------------------------------
// rcf_back
// Owns the frame store. Clears it after reset, then scans each command's box
// one pixel per cycle through a two-step pixel pipe, and reports the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_back #(
  parameter int MAX_WIDTH  = rcf_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = rcf_pkg::MaxHeightDef,
  parameter int PIXEL_BITS = rcf_pkg::PixelBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  wire rcf_pkg::desc_t             q_desc_i,
  output logic                            q_pop_o,
  output logic                            clearing_o,
  output logic                            done_o,
  output logic [rcf_pkg::ColorW-1:0]      read_color_o,
  output logic [rcf_pkg::CntW-1:0]        pixels_written_o
);
  import rcf_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  back_state_e state_q, state_d;

  desc_t                 desc_q;
  logic [CoordW-1:0]     x_q, y_q;
  logic [CntW-1:0]       cnt_q;
  logic [AddrW-1:0]      clr_q;
  logic                  p1_vld_q;
  logic [AddrW-1:0]      p1_addr_q;
  logic [SqW-1:0]        p1_dx2_q, p1_dy2_q;
  logic [PIXEL_BITS-1:0] rdata_q;
  logic [PIXEL_BITS-1:0] mem_q [Depth];

  logic                  row_end, last_pix, clr_last, issue, hit, show_rd;
  logic [SqW-1:0]        row_base;
  logic [SqW:0]          addr_full, dsum;
  logic [CoordW-1:0]     cx_e, cy_e, dx, dy;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [PIXEL_BITS-1:0] mem_wdata;

  assign row_end  = x_q == desc_q.x1;
  assign last_pix = row_end && (y_q == desc_q.y1);
  assign clr_last = clr_q == AddrW'(Depth - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: if (clr_last) state_d = BK_IDLE;
      BK_IDLE: begin
        if (!q_empty_i) begin
          case (q_desc_i.kind)
            KIND_RECT, KIND_CIRC: state_d = q_desc_i.empty ? BK_DONE : BK_SCAN;
            KIND_READ:            state_d = q_desc_i.empty ? BK_DONE : BK_READ;
            default:              state_d = BK_DONE;
          endcase
        end
      end
      BK_SCAN:   if (last_pix) state_d = BK_DRAIN;
      BK_DRAIN:  state_d = BK_DONE;
      BK_READ:   state_d = BK_RDWAIT;
      BK_RDWAIT: state_d = BK_DONE;
      BK_DONE:   state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    q_pop_o    = 1'b0;
    issue      = 1'b0;
    clearing_o = 1'b0;
    done_o     = 1'b0;
    case (state_q)
      BK_CLEAR: clearing_o = 1'b1;
      BK_IDLE:  q_pop_o    = !q_empty_i;
      BK_SCAN:  issue      = 1'b1;
      BK_DONE:  done_o     = 1'b1;
      default: ;
    endcase
  end

  assign show_rd          = done_o && (desc_q.kind == KIND_READ) && !desc_q.empty;
  assign read_color_o     = show_rd ? ColorW'(rdata_q) : '0;
  assign pixels_written_o = done_o ? cnt_q : '0;

  // pixel pipe, first step: address and squared offsets
  assign cx_e      = {1'b0, desc_q.cx};
  assign cy_e      = {1'b0, desc_q.cy};
  assign dx        = (x_q > cx_e) ? x_q - cx_e : cx_e - x_q;
  assign dy        = (y_q > cy_e) ? y_q - cy_e : cy_e - y_q;
  assign row_base  = y_q * desc_q.stride;
  assign addr_full = {1'b0, row_base} + {{(SqW + 1 - CoordW){1'b0}}, x_q};

  // second step: inside test and store write
  assign dsum   = {1'b0, p1_dx2_q} + {1'b0, p1_dy2_q};
  assign hit    = p1_vld_q && ((desc_q.kind != KIND_CIRC) || (dsum <= {1'b0, desc_q.r2}));

  assign mem_we    = clearing_o || hit;
  assign mem_waddr = clearing_o ? clr_q : p1_addr_q;
  assign mem_wdata = clearing_o ? '0 : desc_q.color[PIXEL_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_CLEAR;
      clr_q    <= '0;
      p1_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= issue;
      if (clearing_o) clr_q <= clr_q + 1'b1;
      if (q_pop_o)    cnt_q <= '0;
      else if (hit)   cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_addr_q <= AddrW'(addr_full);
    p1_dx2_q  <= dx * dx;
    p1_dy2_q  <= dy * dy;
    if (q_pop_o) begin
      desc_q <= q_desc_i;
      x_q    <= q_desc_i.x0;
      y_q    <= q_desc_i.y0;
    end else if (issue) begin
      if (row_end) begin
        x_q <= desc_q.x0;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[p1_addr_q];
  end

endmodule

`default_nettype wire

/* design/rcf_checker.sv */
// ----------------------------------------------------------------------------
// rcf_checker
// Port-level checks on the fill engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        busy_o,
  input wire logic                        done_o,
  input wire logic [rcf_pkg::ColorW-1:0]  read_color_o,
  input wire logic [rcf_pkg::CntW-1:0]    pixels_written_o
);

  // store clear runs right after reset, so no word can be taken then
  assert property (@(posedge clk_i) $rose(rst_ni) |-> busy_o)
    else $error("busy_o low right after reset");

  // back end returns to idle between results
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // result ports are quiet between strobes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (read_color_o == '0) && (pixels_written_o == '0))
    else $error("result ports not zero outside strobe");

  // a read never writes pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (read_color_o != '0) |-> pixels_written_o == '0)
    else $error("nonzero read data with pixels written");

endmodule

bind rect_circle_fill_engine_core rcf_checker u_rcf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .read_color_o     (read_color_o),
  .pixels_written_o (pixels_written_o)
);

`default_nettype wire

/* bench/rect_circle_fill_engine_core_tb.sv */
// ----------------------------------------------------------------------------
// rect_circle_fill_engine_core_tb
// Self-checking bench for the rectangle/circle fill engine. A shadow frame
// store is painted for every accepted command word and the count and read
// value it gives are matched against each done_o word. Runs a directed set of
// edge cases, then random commands over a range of frame sizes with changing
// sender idle rates.
// ----------------------------------------------------------------------------

module rect_circle_fill_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcf_pkg::*;

  localparam int StoreDepth = MaxWidthDef * MaxHeightDef;
  localparam int SegItems   = 78;
  localparam int NumSegs    = 9;

  typedef struct {
    cmd_kind_e         kind;
    logic [PosW-1:0]   xa;
    logic [PosW-1:0]   ya;
    logic [CoordW-1:0] xb;
    logic [CoordW-1:0] yb;
    logic [CoordW-1:0] rad;
    logic [ColorW-1:0] color;
  } draw_cmd_t;

  typedef struct {
    logic [ColorW-1:0] color;
    logic [CntW-1:0]   count;
  } draw_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic [CmdW-1:0]     command_i   = '0;
  logic [PosW-1:0]     x_a_i       = '0;
  logic [PosW-1:0]     y_a_i       = '0;
  logic [CoordW-1:0]   x_b_i       = '0;
  logic [CoordW-1:0]   y_b_i       = '0;
  logic [CoordW-1:0]   radius_i    = '0;
  logic [ColorW-1:0]   color_i     = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [ColorW-1:0]   read_color_o;
  logic [CntW-1:0]     pixels_written_o;

  // shadow of the block state
  logic [ColorW-1:0] shadow_store [StoreDepth];
  logic [CfgW-1:0]   width_reg  = FrameWidthRst;
  logic [CfgW-1:0]   height_reg = FrameHeightRst;

  draw_cmd_t    pending_cmds [$];
  draw_result_t due_results [$];

  int gap_pct = 25;
  int err_cnt = 0;
  int n_checked = 0;
  int n_kind [4] = '{0, 0, 0, 0};
  int n_sizes = 0;
  int last_x = 0;
  int last_y = 0;

  rect_circle_fill_engine_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .x_a_i            (x_a_i),
    .y_a_i            (y_a_i),
    .x_b_i            (x_b_i),
    .y_b_i            (y_b_i),
    .radius_i         (radius_i),
    .color_i          (color_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .read_color_o     (read_color_o),
    .pixels_written_o (pixels_written_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int act_w();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidthDef) return MaxWidthDef;
    return int'(width_reg);
  endfunction

  function automatic int act_h();
    if (height_reg == 0) return 1;
    if (height_reg > MaxHeightDef) return MaxHeightDef;
    return int'(height_reg);
  endfunction

  // paints the shadow store and returns what the block should report
  function automatic draw_result_t paint_and_count(draw_cmd_t c);
    draw_result_t res;
    int w, h, cx, cy, rr, xe, ye, x0, x1, y0, y1, dx, dy, n;
    w = act_w();
    h = act_h();
    cx = int'(c.xa);
    cy = int'(c.ya);
    rr = int'(c.rad);
    n = 0;
    res.color = '0;
    case (c.kind)
      KIND_RECT: begin
        xe = (int'(c.xb) > w) ? w : int'(c.xb);
        ye = (int'(c.yb) > h) ? h : int'(c.yb);
        for (int y = cy; y < ye; y++) begin
          for (int x = cx; x < xe; x++) begin
            shadow_store[y * w + x] = c.color;
            n++;
          end
        end
      end
      KIND_CIRC: begin
        // box clamped at zero on the low side, at the frame edge on the high side
        x0 = (cx > rr) ? cx - rr : 0;
        y0 = (cy > rr) ? cy - rr : 0;
        x1 = (cx + rr > w - 1) ? w - 1 : cx + rr;
        y1 = (cy + rr > h - 1) ? h - 1 : cy + rr;
        for (int y = y0; y <= y1; y++) begin
          for (int x = x0; x <= x1; x++) begin
            dx = x - cx;
            dy = y - cy;
            if (dx * dx + dy * dy <= rr * rr) begin
              shadow_store[y * w + x] = c.color;
              n++;
            end
          end
        end
      end
      KIND_READ: begin
        if (cx < w && cy < h) res.color = shadow_store[cy * w + cx];
      end
      default: ;
    endcase
    res.count = CntW'(n);
    return res;
  endfunction

  function automatic draw_cmd_t mk_cmd(cmd_kind_e kind, int xa, int ya, int xb, int yb,
                                       int rad, logic [ColorW-1:0] color);
    draw_cmd_t c;
    c.kind  = kind;
    c.xa    = PosW'(xa);
    c.ya    = PosW'(ya);
    c.xb    = CoordW'(xb);
    c.yb    = CoordW'(yb);
    c.rad   = CoordW'(rad);
    c.color = color;
    return c;
  endfunction

  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c.color = $urandom;
    if (act_w() * act_h() <= 1024 || roll < 3) begin
      // any field value; cheap on small frames, rare on big ones
      c.kind = cmd_kind_e'($urandom_range(0, 3));
      c.xa   = PosW'($urandom);
      c.ya   = PosW'($urandom);
      c.xb   = CoordW'($urandom);
      c.yb   = CoordW'($urandom);
      c.rad  = CoordW'($urandom);
      return c;
    end
    roll = $urandom_range(0, 99);
    c.kind = (roll < 35) ? KIND_RECT : (roll < 65) ? KIND_CIRC :
             (roll < 96) ? KIND_READ : KIND_NOP;
    if ($urandom_range(0, 9) == 0) begin
      c.xa = PosW'($urandom);
      c.ya = PosW'($urandom);
    end else begin
      c.xa = PosW'($urandom_range(0, act_w() - 1));
      c.ya = PosW'($urandom_range(0, act_h() - 1));
    end
    c.xb  = CoordW'(c.xa + $urandom_range(0, 12));
    c.yb  = CoordW'(c.ya + $urandom_range(0, 12));
    if ($urandom_range(0, 9) == 0) c.xb = CoordW'($urandom_range(0, c.xa));
    if ($urandom_range(0, 9) == 0) c.yb = CoordW'($urandom_range(0, c.ya));
    c.rad = CoordW'($urandom_range(0, 8));
    if (c.kind == KIND_READ) begin
      // aim near the last fill so reads see painted pixels
      c.xa = PosW'((last_x + 120 + $urandom_range(0, 16)) % 128);
      c.ya = PosW'((last_y + 120 + $urandom_range(0, 16)) % 128);
    end else begin
      last_x = int'(c.xa);
      last_y = int'(c.ya);
    end
    return c;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == RegFrameWidth) width_reg = val;
    else height_reg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    set_reg(RegFrameWidth, w);
    set_reg(RegFrameHeight, h);
    n_sizes++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // command driver
  always @(posedge clk_i) begin
    logic go;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        n_kind[int'(pending_cmds[0].kind)]++;
        due_results.push_back(paint_and_count(pending_cmds.pop_front()));
      end
      if (start_i && busy_o) go = 1'b1;
      else go = (pending_cmds.size() != 0) && ($urandom_range(0, 99) >= gap_pct);
      start_i <= go;
      if (go) begin
        command_i <= pending_cmds[0].kind;
        x_a_i     <= pending_cmds[0].xa;
        y_a_i     <= pending_cmds[0].ya;
        x_b_i     <= pending_cmds[0].xb;
        y_b_i     <= pending_cmds[0].yb;
        radius_i  <= pending_cmds[0].rad;
        color_i   <= pending_cmds[0].color;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result word with none pending", 32'(pixels_written_o), 0);
      end else begin
        want = due_results.pop_front();
        if (read_color_o !== want.color)
          flag_mismatch("read_color", read_color_o, want.color);
        if (pixels_written_o !== want.count)
          flag_mismatch("pixels_written", 32'(pixels_written_o), 32'(want.count));
        n_checked++;
      end
    end
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int seg_w [NumSegs] = '{128, 1, 0, 8, 255, 37, 128, 64, 100};
    int seg_h [NumSegs] = '{128, 1, 255, 8, 0, 100, 128, 16, 127};
    int seg_gap [NumSegs] = '{25, 25, 25, 86, 86, 86, 0, 0, 0};

    for (int i = 0; i < StoreDepth; i++) shadow_store[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    n_sizes = 1;

    // full frame at reset size: edges, clamps, inverted and empty boxes
    pending_cmds.push_back(mk_cmd(KIND_RECT, 0, 0, 128, 128, 0, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(KIND_READ, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_READ, 127, 127, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_RECT, 0, 0, 255, 255, 255, 32'h0));
    pending_cmds.push_back(mk_cmd(KIND_RECT, 10, 10, 5, 20, 0, 32'h1111_1111));
    pending_cmds.push_back(mk_cmd(KIND_RECT, 3, 3, 3, 9, 0, 32'h2222_2222));
    pending_cmds.push_back(mk_cmd(KIND_RECT, 127, 127, 128, 128, 0, 32'hA5A5_5A5A));
    pending_cmds.push_back(mk_cmd(KIND_READ, 127, 127, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_CIRC, 0, 0, 0, 0, 0, 32'h0F0F_F0F0));
    pending_cmds.push_back(mk_cmd(KIND_CIRC, 127, 127, 0, 0, 3, 32'h3333_3333));
    pending_cmds.push_back(mk_cmd(KIND_CIRC, 64, 64, 0, 0, 255, 32'h1234_5678));
    pending_cmds.push_back(mk_cmd(KIND_CIRC, 5, 5, 0, 0, 10, 32'hDEAD_BEEF));
    pending_cmds.push_back(mk_cmd(KIND_READ, 5, 5, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_READ, 0, 127, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_NOP, 127, 127, 255, 255, 255, 32'hFFFF_FFFF));
    wait_idle();

    // small frame: positions beyond the frame
    set_frame(CfgW'(16), CfgW'(16));
    pending_cmds.push_back(mk_cmd(KIND_READ, 100, 5, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_READ, 5, 100, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_CIRC, 120, 120, 0, 0, 5, 32'h4444_4444));
    pending_cmds.push_back(mk_cmd(KIND_CIRC, 120, 3, 0, 0, 110, 32'h5555_5555));
    pending_cmds.push_back(mk_cmd(KIND_RECT, 20, 0, 30, 4, 0, 32'h6666_6666));
    pending_cmds.push_back(mk_cmd(KIND_RECT, 14, 14, 200, 200, 0, 32'h7777_7777));
    pending_cmds.push_back(mk_cmd(KIND_READ, 15, 15, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(KIND_READ, 9, 3, 0, 0, 0, 0));
    wait_idle();

    for (int s = 0; s < NumSegs; s++) begin
      set_frame(CfgW'(seg_w[s]), CfgW'(seg_h[s]));
      gap_pct = seg_gap[s];
      repeat (SegItems) pending_cmds.push_back(rand_cmd());
      wait_idle();
    end

    if (due_results.size() != 0) flag_mismatch("results never returned", due_results.size(), 0);
    $display("Checked %0d result words over %0d frame sizes.", n_checked, n_sizes);
    $display("Commands: %0d rect, %0d circle, %0d read, %0d undefined.",
             n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
